FILE: sv/fcte_pkg.sv
// Package for the FAT32 cluster table engine: sizes, entry markers, operation
// and status codes, beat types and entry classification functions.
// No dependencies; used by fcte_core and fat_cluster_table_engine_unit.
package fcte_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int CLUSTER_W = 13;
  localparam int VALUE_W   = 32;
  localparam int FREED_W   = 14;
  localparam int START_W   = 13;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [VALUE_W-1:0] ENTRY_MASK = 32'h0FFF_FFFF;
  localparam logic [VALUE_W-1:0] EOC_MARK   = 32'h0FFF_FFF8;
  localparam logic [VALUE_W-1:0] BAD_MARK   = 32'h0FFF_FFF7;
  localparam logic [VALUE_W-1:0] FREE_MARK  = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] DEPTH_VAL  = VALUE_W'(TABLE_DEPTH);
  localparam logic [FREED_W-1:0] FREED_MAX  = '1;

  localparam logic [START_W-1:0] ALLOC_START_RESET = START_W'(5);
  // Register select: byte address bit 2 gives the register index.
  localparam logic [0:0] REG_ALLOC_START = 1'b0;

  typedef enum logic [1:0] {
    OP_NEXT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_SET   = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_EOC  = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  operation;
    logic [CLUSTER_W-1:0] cluster;
    logic [VALUE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   result_value;
    logic [FREED_W-1:0]   freed_count;
  } out_item_t;

  function automatic logic is_eoc(input logic [VALUE_W-1:0] v);
    return (v & ENTRY_MASK) >= EOC_MARK;
  endfunction

  function automatic logic is_bad(input logic [VALUE_W-1:0] v);
    return (v & ENTRY_MASK) == BAD_MARK;
  endfunction

  function automatic logic is_free(input logic [VALUE_W-1:0] v);
    return (v & ENTRY_MASK) == FREE_MARK;
  endfunction

  function automatic logic is_invalid_link(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] m;
    m = v & ENTRY_MASK;
    return (m == VALUE_W'(1)) || ((m >= DEPTH_VAL) && (m < BAD_MARK));
  endfunction

endpackage

FILE: sv/fcte_core.sv
// Table sequencer: cluster table memory, reset clearing pass, next lookup,
// allocate scan, set and chain free, and the output register.
// Depends on fcte_pkg.
module fcte_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [fcte_pkg::START_W-1:0]  alloc_start,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcte_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcte_pkg::out_item_t           out_data
);
  import fcte_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_CHAIN,
    S_FINISH
  } state_t;

  state_t             state, state_next;
  out_item_t          res, res_next;
  out_item_t          out_data_next;
  logic               out_valid_next;
  logic [CNT_W-1:0]   scan_addr, scan_addr_next;
  logic [IDX_W-1:0]   cur, cur_next;
  logic [FREED_W-1:0] count, count_next;

  // Memory ports
  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [VALUE_W-1:0] wdata, ram_q, fwd_data, rd_data;
  logic               fwd;

  logic [VALUE_W-1:0] masked;
  logic [FREED_W-1:0] cnt_inc;
  logic               in_range, start_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ram_q <= mem[raddr];
  end

  // A read of the entry written in the same cycle returns the new value.
  assign rd_data  = fwd ? fwd_data : ram_q;
  assign masked   = rd_data & ENTRY_MASK;
  assign cnt_inc  = (count == FREED_MAX) ? count : count + FREED_W'(1);
  assign in_range = {{(VALUE_W-CLUSTER_W){1'b0}}, in_data.cluster} < DEPTH_VAL;
  assign start_ok = {{(VALUE_W-START_W){1'b0}}, alloc_start} < DEPTH_VAL;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    res_next       = res;
    scan_addr_next = scan_addr;
    cur_next       = cur;
    count_next     = count;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    we             = 1'b0;
    waddr          = cur;
    wdata          = FREE_MARK;
    raddr          = cur;

    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = IDX_W'(scan_addr);
        if (scan_addr == CNT_W'(TABLE_DEPTH - 1)) begin
          scan_addr_next = '0;
          state_next     = S_IDLE;
        end else begin
          scan_addr_next = scan_addr + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          res_next   = '{status: ST_OK, result_value: '0, freed_count: '0};
          cur_next   = IDX_W'(in_data.cluster);
          count_next = '0;
          unique case (in_data.operation)
            OP_NEXT: begin
              if (in_range) begin
                raddr      = IDX_W'(in_data.cluster);
                state_next = S_LOOKUP;
              end else begin
                res_next.status = ST_BAD;
                state_next      = S_FINISH;
              end
            end
            OP_ALLOC: begin
              if (start_ok) begin
                raddr          = IDX_W'(alloc_start);
                cur_next       = IDX_W'(alloc_start);
                scan_addr_next = CNT_W'(alloc_start) + CNT_W'(1);
                state_next     = S_SCAN;
              end else begin
                res_next.status = ST_FULL;
                state_next      = S_FINISH;
              end
            end
            OP_SET: begin
              if (in_range) begin
                we    = 1'b1;
                waddr = IDX_W'(in_data.cluster);
                wdata = in_data.value;
              end else begin
                res_next.status = ST_BAD;
              end
              state_next = S_FINISH;
            end
            OP_FREE: begin
              if (in_range && (in_data.cluster >= CLUSTER_W'(2))) begin
                raddr      = IDX_W'(in_data.cluster);
                state_next = S_CHAIN;
              end else begin
                res_next.status = ST_BAD;
                state_next      = S_FINISH;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_LOOKUP: begin
        res_next.result_value = rd_data;
        if (is_eoc(rd_data)) begin
          res_next.status = ST_EOC;
        end else if (is_bad(rd_data) || is_invalid_link(rd_data)) begin
          res_next.status = ST_BAD;
        end else begin
          res_next.status = ST_OK;
        end
        state_next = S_FINISH;
      end

      // The entry at cur is checked while the read of the next one is issued.
      S_SCAN: begin
        if (is_free(rd_data)) begin
          we                    = 1'b1;
          waddr                 = cur;
          wdata                 = EOC_MARK;
          res_next.result_value = VALUE_W'(cur);
          state_next            = S_FINISH;
        end else if (scan_addr == CNT_W'(TABLE_DEPTH)) begin
          res_next.status = ST_FULL;
          state_next      = S_FINISH;
        end else begin
          raddr          = IDX_W'(scan_addr);
          cur_next       = IDX_W'(scan_addr);
          scan_addr_next = scan_addr + CNT_W'(1);
        end
      end

      S_CHAIN: begin
        if (is_free(rd_data) || is_bad(rd_data)) begin
          res_next.status      = ST_BAD;
          res_next.freed_count = count;
          state_next           = S_FINISH;
        end else begin
          we    = 1'b1;
          waddr = cur;
          wdata = FREE_MARK;
          if (is_eoc(rd_data)) begin
            res_next.status      = ST_OK;
            res_next.freed_count = cnt_inc;
            state_next           = S_FINISH;
          end else if (is_invalid_link(rd_data)) begin
            res_next.status      = ST_BAD;
            res_next.freed_count = cnt_inc;
            state_next           = S_FINISH;
          end else begin
            // A valid link lies below the table depth, so it fits the index.
            raddr      = IDX_W'(masked);
            cur_next   = IDX_W'(masked);
            count_next = cnt_inc;
          end
        end
      end

      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    cur      <= cur_next;
    count    <= count_next;
    out_data <= out_data_next;
    fwd_data <= wdata;
    if (rst) begin
      state     <= S_CLEAR;
      scan_addr <= '0;
      out_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      state     <= state_next;
      scan_addr <= scan_addr_next;
      out_valid <= out_valid_next;
      fwd       <= we && (waddr == raddr);
    end
  end

endmodule

FILE: sv/fat_cluster_table_engine_unit.sv
// Top level of the FAT32 cluster table engine: configuration register port
// and the table sequencer. Depends on fcte_pkg and fcte_core.
//
//   channel   signals                               beat carries
//   in        in_valid, in_stall, in_data           operation, cluster, value
//   out       out_valid, out_stall, out_data        status, result_value, freed_count
//   config    psel, penable, pwrite, paddr, pwdata  alloc_start at byte address 0
//
// One operation is in work at a time. Allocate scans the table one entry per
// step and marks the first free entry end of chain; free chain visits one entry
// per step, clearing each that it passes with a read-modify-write of the table memory.
// After reset the table's 8192 entries are cleared one entry a cycle, with
// in_stall high; configuration writes are taken throughout. A new input beat
// is taken while a result waits in the output register; a stall on the
// output holds the next result in the sequencer until the register drains.
module fat_cluster_table_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcte_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcte_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcte_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcte_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcte_pkg::out_item_t           out_data
);
  import fcte_pkg::*;

  logic [START_W-1:0] alloc_start;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_ALLOC_START);
  assign prdata  = reg_sel ? PDATA_W'(alloc_start) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_start <= ALLOC_START_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      alloc_start <= pwdata[START_W-1:0];
    end
  end

  fcte_core u_core (
    .clk         (clk),
    .rst         (rst),
    .alloc_start (alloc_start),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: verif/fcte_table_checker.sv
// Checker for the FAT32 cluster table engine: follows the configuration port and
// both beat channels, keeps its own copy of the table and compares every result.
// Depends on fcte_pkg; instantiated beside the block by fat_cluster_table_engine_unit_tb.
module fcte_table_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcte_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcte_pkg::PDATA_W-1:0]  pwdata,
  input  logic [fcte_pkg::PDATA_W-1:0]  prdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fcte_pkg::in_item_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  fcte_pkg::out_item_t           out_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            cleared,
  output int                            full_scans
);
  import fcte_pkg::*;

  typedef enum logic [2:0] {K_FREE, K_LINK, K_EOC, K_BAD, K_BROKEN} entry_kind_t;

  logic [VALUE_W-1:0] entries [TABLE_DEPTH];
  logic [START_W-1:0] alloc_base;
  out_item_t          due_results [$];
  int                 fails, n_checked, n_cleared, n_full;

  // Only the low 28 bits of an entry carry meaning; the top nibble is reserved.
  function automatic entry_kind_t kind_of(logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] m;
    m = v & ENTRY_MASK;
    if (m == FREE_MARK) return K_FREE;
    if (m >= EOC_MARK) return K_EOC;
    if (m == BAD_MARK) return K_BAD;
    if (m == VALUE_W'(1) || m >= VALUE_W'(TABLE_DEPTH)) return K_BROKEN;
    return K_LINK;
  endfunction

  function automatic out_item_t serve_op(in_item_t beat);
    out_item_t          res;
    logic [VALUE_W-1:0] v;
    entry_kind_t        k;
    int                 cur, n;
    logic               done;
    res = '0;
    case (beat.operation)
      OP_NEXT: begin
        v = entries[beat.cluster];
        res.result_value = v;
        case (kind_of(v))
          K_EOC:           res.status = ST_EOC;
          K_BAD, K_BROKEN: res.status = ST_BAD;
          default:         res.status = ST_OK;
        endcase
      end
      OP_ALLOC: begin
        cur = int'(alloc_base);
        done = 1'b0;
        while (!done && cur < TABLE_DEPTH) begin
          if (kind_of(entries[cur]) == K_FREE) done = 1'b1;
          else cur++;
        end
        if (done) begin
          entries[cur] = EOC_MARK;
          res.result_value = VALUE_W'(cur);
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_SET: entries[beat.cluster] = beat.value;
      default: begin
        // Chain free: an entry that stops the walk before clearing is left as it is.
        cur = int'(beat.cluster);
        n = 0;
        done = 1'b0;
        while (!done) begin
          if (cur < 2 || cur >= TABLE_DEPTH) begin
            res.status = ST_BAD;
            done = 1'b1;
          end else begin
            v = entries[cur];
            k = kind_of(v);
            if (k == K_FREE || k == K_BAD) begin
              res.status = ST_BAD;
              done = 1'b1;
            end else begin
              entries[cur] = FREE_MARK;
              if (n < int'(FREED_MAX)) n++;
              if (k == K_EOC) begin
                done = 1'b1;
              end else if (k == K_BROKEN) begin
                res.status = ST_BAD;
                done = 1'b1;
              end else begin
                cur = int'(v & ENTRY_MASK);
              end
            end
          end
        end
        res.freed_count = FREED_W'(n);
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t res, want;
    logic      bad_beat;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) entries[i] = FREE_MARK;
      alloc_base = ALLOC_START_RESET;
      due_results.delete();
      fails = 0;
      n_checked = 0;
      n_cleared = 0;
      n_full = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == REG_ALLOC_START) begin
        if (pwrite) begin
          alloc_base = pwdata[START_W-1:0];
        end else if (prdata !== PDATA_W'(alloc_base)) begin
          $display("%0t: alloc_start read back expected %0d, got %0d", $time, alloc_base, prdata);
          fails++;
        end
      end
      if (in_valid && !in_stall) begin
        res = serve_op(in_data);
        due_results.push_back(res);
        n_cleared += int'(res.freed_count);
        if (res.status == ST_FULL) n_full++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with no operation outstanding: %p", $time, out_data);
          fails++;
        end else begin
          want = due_results.pop_front();
          bad_beat = 1'b0;
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
            bad_beat = 1'b1;
          end
          if (out_data.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h, got %h", $time, want.result_value,
                     out_data.result_value);
            bad_beat = 1'b1;
          end
          if (out_data.freed_count !== want.freed_count) begin
            $display("%0t: freed_count expected %0d, got %0d", $time, want.freed_count,
                     out_data.freed_count);
            bad_beat = 1'b1;
          end
          if (bad_beat) fails++;
          n_checked++;
        end
      end
    end
    fail_count <= fails;
    pending    <= due_results.size();
    checked    <= n_checked;
    cleared    <= n_cleared;
    full_scans <= n_full;
  end

endmodule

FILE: verif/fat_cluster_table_engine_unit_tb.sv
// Testbench top for fat_cluster_table_engine_unit: clock, reset, table operations,
// configuration writes and the verdict. Depends on fcte_pkg, the block and
// fcte_table_checker, which does all prediction and comparison.
module fat_cluster_table_engine_unit_tb;
  import fcte_pkg::*;

  localparam int QUIET_LIMIT = 60000;
  localparam int PHASE_ITEMS = 120;
  localparam int HOT_SPAN    = 64;

  typedef enum int {V_LINK, V_EOC, V_BAD, V_BROKEN, V_FREE, V_RAW} entry_pick_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata, prdata;
  logic                 in_valid, in_stall, out_valid;
  logic                 out_stall = 1'b0;
  in_item_t             in_data;
  out_item_t            out_data;

  int                   idle_pct = 19;
  int                   stall_pct = 19;
  int                   ops_sent = 0;
  int                   settings_used = 1;
  int                   fail_count, pending, checked, cleared, full_scans;
  logic [CLUSTER_W-1:0] hot_base;
  logic [CLUSTER_W-1:0] chain_nodes [48];

  always #1 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  fat_cluster_table_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fcte_table_checker table_chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .cleared    (cleared),
    .full_scans (full_scans)
  );

  // Called just after a rising edge; returns at the edge at which the beat is taken,
  // leaving valid high so that the next beat can follow without a gap.
  task automatic issue(op_t op, logic [CLUSTER_W-1:0] c, logic [VALUE_W-1:0] v);
    logic took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op, c, v};
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
    ops_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [PDATA_W-1:0] data);
    logic took;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({REG_ALLOC_START, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = pready;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_alloc_start(logic [START_W-1:0] s);
    quiesce();
    apb_access(1'b1, PDATA_W'(s));
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  function automatic logic [VALUE_W-1:0] pick_entry(entry_pick_t k, logic [CLUSTER_W-1:0] target);
    logic [VALUE_W-1:0] nibble;
    nibble = {4'($urandom), 28'd0};
    case (k)
      V_LINK:   return nibble | VALUE_W'(target);
      V_EOC:    return nibble | (EOC_MARK + VALUE_W'($urandom_range(7)));
      V_BAD:    return nibble | BAD_MARK;
      V_BROKEN: begin
        if ($urandom_range(1) == 0) return nibble | VALUE_W'(1);
        return nibble | VALUE_W'($urandom_range(TABLE_DEPTH, BAD_MARK - 1));
      end
      V_FREE:   return nibble;
      default:  return $urandom;
    endcase
  endfunction

  function automatic entry_pick_t chain_end();
    int r;
    r = $urandom_range(9);
    if (r < 7) return V_EOC;
    if (r == 7) return V_BAD;
    if (r == 8) return V_BROKEN;
    return V_FREE;
  endfunction

  function automatic logic [CLUSTER_W-1:0] hot_cluster();
    return CLUSTER_W'(hot_base + $urandom_range(HOT_SPAN - 1));
  endfunction

  // Links a handful of entries in the hot window, ends the chain, then half the time
  // looks at one entry and usually frees the chain from its head. Repeated nodes make loops.
  task automatic build_chain();
    int len;
    len = ($urandom_range(19) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) chain_nodes[k] = hot_cluster();
    for (int k = 0; k < len - 1; k++)
      issue(OP_SET, chain_nodes[k], pick_entry(V_LINK, chain_nodes[k+1]));
    issue(OP_SET, chain_nodes[len-1], pick_entry(chain_end(), '0));
    if ($urandom_range(1) == 0) issue(OP_NEXT, chain_nodes[$urandom_range(len - 1)], $urandom);
    if ($urandom_range(3) != 0) issue(OP_FREE, chain_nodes[0], $urandom);
  endtask

  task automatic run_phase(int n);
    int  stop, r;
    op_t op;
    stop = ops_sent + n;
    while (ops_sent < stop) begin
      r = $urandom_range(99);
      if (r < 50) begin
        build_chain();
      end else if (r < 65) begin
        repeat ($urandom_range(1, 3)) issue(OP_ALLOC, CLUSTER_W'($urandom), $urandom);
      end else if (r < 85) begin
        op = op_t'($urandom_range(3));
        issue(op, hot_cluster(), pick_entry(entry_pick_t'($urandom_range(5)), hot_cluster()));
      end else begin
        op = op_t'($urandom_range(3));
        issue(op, CLUSTER_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("fat_cluster_table_engine_unit test failed");
    $finish;
  end

  initial begin
    int s;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, alloc_start still at its reset value. The first beat waits
    // out the clearing pass.
    issue(OP_NEXT, 13'd0, $urandom);
    issue(OP_NEXT, 13'h1FFF, $urandom);
    issue(OP_ALLOC, 13'd0, $urandom);
    issue(OP_ALLOC, 13'h1FFF, $urandom);
    issue(OP_SET, 13'd5, 32'd6);
    issue(OP_SET, 13'd6, 32'hF000_0007);   // reserved nibble set on a link
    issue(OP_SET, 13'd7, 32'hFFFF_FFFF);
    issue(OP_NEXT, 13'd5, $urandom);
    issue(OP_NEXT, 13'd7, $urandom);
    issue(OP_SET, 13'd8, BAD_MARK);
    issue(OP_NEXT, 13'd8, $urandom);
    issue(OP_SET, 13'd9, 32'd1);
    issue(OP_NEXT, 13'd9, $urandom);
    issue(OP_SET, 13'd10, VALUE_W'(TABLE_DEPTH));
    issue(OP_NEXT, 13'd10, $urandom);
    issue(OP_SET, 13'd11, BAD_MARK - 1);
    issue(OP_NEXT, 13'd11, $urandom);
    issue(OP_FREE, 13'd5, $urandom);
    issue(OP_FREE, 13'd8, $urandom);
    issue(OP_FREE, 13'd1, $urandom);
    issue(OP_FREE, 13'd9, $urandom);
    issue(OP_SET, 13'd12, 32'd13);
    issue(OP_SET, 13'd13, 32'd12);
    issue(OP_FREE, 13'd12, $urandom);
    issue(OP_SET, 13'h1FFF, 32'hFFFF_FFFF);

    // Only the top entry can be scanned, so the first and third allocations find nothing.
    set_alloc_start(START_W'(TABLE_DEPTH - 1));
    issue(OP_ALLOC, 13'd0, $urandom);
    issue(OP_SET, 13'h1FFF, FREE_MARK);
    issue(OP_ALLOC, 13'd0, $urandom);
    issue(OP_ALLOC, 13'd0, $urandom);
    set_alloc_start('0);
    issue(OP_ALLOC, 13'd0, $urandom);
    issue(OP_ALLOC, 13'd0, $urandom);

    hot_base = CLUSTER_W'($urandom_range(TABLE_DEPTH - HOT_SPAN));
    run_phase(PHASE_ITEMS);
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       s = TABLE_DEPTH - 1;
        1:       s = 2;
        2:       s = TABLE_DEPTH / 2;
        3:       s = TABLE_DEPTH - 2;
        4:       s = $urandom_range(TABLE_DEPTH - 1);
        5:       s = $urandom_range(100);
        default: s = int'(ALLOC_START_RESET);
      endcase
      set_alloc_start(START_W'(s));
      // Half the time, where it fits, the hot window sits where the allocator scans.
      if ($urandom_range(1) == 0 && s <= TABLE_DEPTH - HOT_SPAN) hot_base = CLUSTER_W'(s);
      else hot_base = CLUSTER_W'($urandom_range(TABLE_DEPTH - HOT_SPAN));
      idle_pct  = (p == 2) ? 0 : 19;
      stall_pct = (p == 2) ? 0 : 19;
      run_phase(PHASE_ITEMS);
    end
    quiesce();
    repeat (16) @(posedge clk);

    $display("Summary: %0d table operations under %0d alloc_start settings, %0d results checked.",
             ops_sent, settings_used, checked);
    $display("Summary: chain frees cleared %0d entries; %0d allocations found no free cluster.",
             cleared, full_scans);
    if (fail_count == 0) begin
      $display("fat_cluster_table_engine_unit test passed");
    end else begin
      $display("fat_cluster_table_engine_unit test failed");
    end
    $finish;
  end

endmodule
